@@ hw/rtl/kmf_pkg.sv @@
// ----------------------------------------------------------------------------
// kmf_pkg
// Shared types and constants for the keyed multi-queue FIFO block.
// ----------------------------------------------------------------------------
package kmf_pkg;

    localparam int KeyW     = 32;
    localparam int OpW      = 2;
    localparam int StatusW  = 2;
    localparam int RecPortW = 64;

    // defaults for the top-level parameters
    localparam int NumQueuesDef   = 8;
    localparam int QueueDepthDef  = 16;
    localparam int RecordWidthDef = 64;

    typedef enum logic [OpW-1:0] {
        OP_REGISTER   = 2'd0,
        OP_UNREGISTER = 2'd1,
        OP_PUSH       = 2'd2,
        OP_POP        = 2'd3
    } op_t;

    typedef enum logic [StatusW-1:0] {
        STAT_OK        = 2'd0,
        STAT_NOT_FOUND = 2'd1,
        STAT_FULL      = 2'd2,
        STAT_EMPTY     = 2'd3
    } status_t;

endpackage

@@ hw/rtl/kmf_ram.sv @@
// ----------------------------------------------------------------------------
// kmf_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module kmf_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 16
) (
    input  logic                                          aclk,
    input  logic                                          wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [DATA_W-1:0]                             wr_data,
    input  logic                                          rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [DATA_W-1:0]                             rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        // read data holds until the next read
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ hw/rtl/keyed_multi_fifo.sv @@
// Sequence: input capture, lookup with pointer RAM read, execute; a successful
//   pop adds a record RAM read. Results are registered and wait on m_ready.
// Flow: one transaction at a time; s_ready is high only in idle, so a new one
//   waits for the lookup / pointer RAM read / record RAM read sequence.
// Reset: synchronous, active low; all slots free, all queue pointers read as
//   zero at once (per-slot valid bits), no clearing pass. Records need no reset.
// ----------------------------------------------------------------------------
// keyed_multi_fifo
// Set of key-bound queue slots, each a FIFO of records held in a shared RAM.
// ----------------------------------------------------------------------------
module keyed_multi_fifo #(
    parameter int NUM_QUEUES   = kmf_pkg::NumQueuesDef,
    parameter int QUEUE_DEPTH  = kmf_pkg::QueueDepthDef,
    parameter int RECORD_WIDTH = kmf_pkg::RecordWidthDef
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // input channel
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [kmf_pkg::OpW-1:0]       s_operation,
    input  logic [kmf_pkg::KeyW-1:0]      s_queue_key,
    input  logic [kmf_pkg::RecPortW-1:0]  s_push_record,
    // result channel
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [kmf_pkg::StatusW-1:0]   m_status,
    output logic [kmf_pkg::RecPortW-1:0]  m_popped_record
);

    // ------------------------------------------------------------------
    // Derived widths
    // ------------------------------------------------------------------
    localparam int SlotW    = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam int HeadW    = $clog2(QUEUE_DEPTH);
    localparam int CntW     = $clog2(QUEUE_DEPTH + 1);
    localparam int PtrW     = HeadW + CntW;
    localparam int RecDepth = NUM_QUEUES * QUEUE_DEPTH;
    localparam int RecAddrW = $clog2(RecDepth);

    // Controller states, one-hot
    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,  // waiting for a transaction
        ST_LOOKUP = 4'b0010,  // key match, pointer RAM read issued
        ST_EXEC   = 4'b0100,  // pointers available, operation performed
        ST_POPRD  = 4'b1000   // record RAM read data available
    } state_t;

    state_t state_reg, state_next;

    // ------------------------------------------------------------------
    // Captured transaction
    // ------------------------------------------------------------------
    kmf_pkg::op_t              op_reg;
    logic [kmf_pkg::KeyW-1:0]  qkey_reg;
    logic [RECORD_WIDTH-1:0]   rec_reg;

    // ------------------------------------------------------------------
    // Slot table: in-use flags and keys in flops for the parallel match
    // ------------------------------------------------------------------
    logic [NUM_QUEUES-1:0]     in_use_reg, in_use_next;
    logic [kmf_pkg::KeyW-1:0]  key_reg [NUM_QUEUES];
    logic                      key_we;

    // Per-slot pointer valid bits: a slot never written reads head=0, count=0
    logic [NUM_QUEUES-1:0]     ptr_vld_reg, ptr_vld_next;

    // Selected slot, latched at the end of lookup
    logic [SlotW-1:0]          slot_reg, slot_next;
    logic                      found_reg, found_next;

    // Result register, decouples the output handshake from the controller
    logic                           m_valid_reg, m_valid_next;
    kmf_pkg::status_t               m_status_reg, m_status_next;
    logic [kmf_pkg::RecPortW-1:0]   m_popped_record_reg, m_popped_record_next;

    // ------------------------------------------------------------------
    // Key match and free-slot search, lowest index wins
    // ------------------------------------------------------------------
    logic             hit;
    logic [SlotW-1:0] hit_idx;
    logic             free_any;
    logic [SlotW-1:0] free_idx;

    always_comb begin
        hit      = 1'b0;
        hit_idx  = '0;
        free_any = 1'b0;
        free_idx = '0;
        for (int s = NUM_QUEUES - 1; s >= 0; s--) begin
            if (in_use_reg[s] && (key_reg[s] == qkey_reg)) begin
                hit     = 1'b1;
                hit_idx = SlotW'(s);
            end
            if (!in_use_reg[s]) begin
                free_any = 1'b1;
                free_idx = SlotW'(s);
            end
        end
    end

    // ------------------------------------------------------------------
    // Pointer RAM: {head, count} per slot
    // ------------------------------------------------------------------
    logic            ptr_re;
    logic            ptr_we;
    logic [PtrW-1:0] ptr_wdata;
    logic [PtrW-1:0] ptr_rdata;

    kmf_ram #(
        .DATA_W (PtrW),
        .DEPTH  (NUM_QUEUES)
    ) u_ptr_ram (
        .aclk    (aclk),
        .wr_en   (ptr_we),
        .wr_addr (slot_reg),
        .wr_data (ptr_wdata),
        .rd_en   (ptr_re),
        .rd_addr (slot_next),
        .rd_data (ptr_rdata)
    );

    // Current pointers of the selected slot (valid bit gates never-written slots)
    logic [HeadW-1:0] cur_head;
    logic [CntW-1:0]  cur_cnt;

    assign cur_head = ptr_vld_reg[slot_reg] ? ptr_rdata[PtrW-1:CntW] : '0;
    assign cur_cnt  = ptr_vld_reg[slot_reg] ? ptr_rdata[CntW-1:0]    : '0;

    // Tail = (head + count) mod depth; sum stays below twice the depth
    logic [HeadW:0]   tail_sum;
    logic [HeadW-1:0] tail_pos;
    logic [HeadW-1:0] head_inc;

    assign tail_sum = (HeadW + 1)'(cur_head) + (HeadW + 1)'(cur_cnt);
    assign tail_pos = (tail_sum >= (HeadW + 1)'(QUEUE_DEPTH))
                    ? HeadW'(tail_sum - (HeadW + 1)'(QUEUE_DEPTH))
                    : HeadW'(tail_sum);
    assign head_inc = (cur_head == HeadW'(QUEUE_DEPTH - 1)) ? '0 : cur_head + 1'b1;

    // ------------------------------------------------------------------
    // Record RAM: slot s owns entries s*QUEUE_DEPTH .. s*QUEUE_DEPTH+QUEUE_DEPTH-1
    // ------------------------------------------------------------------
    logic                    rec_we;
    logic                    rec_re;
    logic [RecAddrW-1:0]     rec_base;
    logic [RecAddrW-1:0]     rec_waddr;
    logic [RecAddrW-1:0]     rec_raddr;
    logic [RECORD_WIDTH-1:0] rec_rdata;

    assign rec_base  = RecAddrW'(RecAddrW'(slot_reg) * RecAddrW'(QUEUE_DEPTH));
    assign rec_waddr = rec_base + RecAddrW'(tail_pos);
    assign rec_raddr = rec_base + RecAddrW'(cur_head);

    kmf_ram #(
        .DATA_W (RECORD_WIDTH),
        .DEPTH  (RecDepth)
    ) u_rec_ram (
        .aclk    (aclk),
        .wr_en   (rec_we),
        .wr_addr (rec_waddr),
        .wr_data (rec_reg),
        .rd_en   (rec_re),
        .rd_addr (rec_raddr),
        .rd_data (rec_rdata)
    );

    // ------------------------------------------------------------------
    // Controller
    // ------------------------------------------------------------------
    logic out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE);

    always_comb begin
        state_next           = state_reg;
        in_use_next          = in_use_reg;
        ptr_vld_next         = ptr_vld_reg;
        slot_next            = slot_reg;
        found_next           = found_reg;
        key_we               = 1'b0;
        ptr_re               = 1'b0;
        ptr_we               = 1'b0;
        ptr_wdata            = {cur_head, cur_cnt};
        rec_we               = 1'b0;
        rec_re               = 1'b0;
        m_valid_next         = m_valid_reg && !m_ready;
        m_status_next        = m_status_reg;
        m_popped_record_next = m_popped_record_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_LOOKUP;
                end
            end

            ST_LOOKUP: begin
                // register binds the lowest free slot, the rest use the lowest match
                if (op_reg == kmf_pkg::OP_REGISTER) begin
                    slot_next  = free_idx;
                    found_next = free_any;
                end else begin
                    slot_next  = hit_idx;
                    found_next = hit;
                end
                ptr_re     = 1'b1;
                state_next = ST_EXEC;
            end

            ST_EXEC: begin
                if (out_free) begin
                    m_valid_next         = 1'b1;
                    m_status_next        = kmf_pkg::STAT_NOT_FOUND;
                    m_popped_record_next = '0;
                    state_next           = ST_IDLE;
                    if (found_reg) begin
                        case (op_reg)
                            kmf_pkg::OP_REGISTER: begin
                                in_use_next[slot_reg] = 1'b1;
                                key_we                = 1'b1;
                                m_status_next         = kmf_pkg::STAT_OK;
                            end
                            kmf_pkg::OP_UNREGISTER: begin
                                // contents stay, the slot is only marked free
                                in_use_next[slot_reg] = 1'b0;
                                m_status_next         = kmf_pkg::STAT_OK;
                            end
                            kmf_pkg::OP_PUSH: begin
                                if (cur_cnt >= CntW'(QUEUE_DEPTH)) begin
                                    m_status_next = kmf_pkg::STAT_FULL;
                                end else begin
                                    rec_we                 = 1'b1;
                                    ptr_we                 = 1'b1;
                                    ptr_wdata              = {cur_head, cur_cnt + 1'b1};
                                    ptr_vld_next[slot_reg] = 1'b1;
                                    m_status_next          = kmf_pkg::STAT_OK;
                                end
                            end
                            kmf_pkg::OP_POP: begin
                                if (cur_cnt == '0) begin
                                    m_status_next = kmf_pkg::STAT_EMPTY;
                                end else begin
                                    // result waits for the record read
                                    rec_re                 = 1'b1;
                                    ptr_we                 = 1'b1;
                                    ptr_wdata              = {head_inc, cur_cnt - 1'b1};
                                    ptr_vld_next[slot_reg] = 1'b1;
                                    m_valid_next           = m_valid_reg && !m_ready;
                                    m_status_next          = m_status_reg;
                                    m_popped_record_next   = m_popped_record_reg;
                                    state_next             = ST_POPRD;
                                end
                            end
                            default: begin
                                m_status_next = kmf_pkg::STAT_NOT_FOUND;
                            end
                        endcase
                    end
                end
            end

            ST_POPRD: begin
                if (out_free) begin
                    m_valid_next         = 1'b1;
                    m_status_next        = kmf_pkg::STAT_OK;
                    m_popped_record_next = kmf_pkg::RecPortW'(rec_rdata);
                    state_next           = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            in_use_reg  <= '0;
            ptr_vld_reg <= '0;
            m_valid_reg <= 1'b0;
            found_reg   <= 1'b0;
        end else begin
            state_reg   <= state_next;
            in_use_reg  <= in_use_next;
            ptr_vld_reg <= ptr_vld_next;
            m_valid_reg <= m_valid_next;
            found_reg   <= found_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            op_reg   <= kmf_pkg::op_t'(s_operation);
            qkey_reg <= s_queue_key;
            rec_reg  <= s_push_record[RECORD_WIDTH-1:0];
        end
        if (key_we) begin
            key_reg[slot_reg] <= qkey_reg;
        end
        slot_reg            <= slot_next;
        m_status_reg        <= m_status_next;
        m_popped_record_reg <= m_popped_record_next;
    end

    assign m_valid         = m_valid_reg;
    assign m_status        = m_status_reg;
    assign m_popped_record = m_popped_record_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
`ifndef SYNTH
    // a record is written only into a queue with room
    a_push_room: assert property (@(posedge aclk) disable iff (!aresetn)
        rec_we |-> (cur_cnt < CntW'(QUEUE_DEPTH)))
        else $error("record write into full queue");

    // a pop reads only a non-empty queue
    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        rec_re |-> (cur_cnt != '0))
        else $error("record read from empty queue");

    // a record read is always followed by the pop-read state, which consumes its data
    a_pop_follow: assert property (@(posedge aclk) disable iff (!aresetn)
        rec_re |=> (state_reg == ST_POPRD))
        else $error("record read data not consumed");

    // new results come only out of the execute or pop-read steps
    a_result_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> ($past(state_reg == ST_EXEC) || $past(state_reg == ST_POPRD)))
        else $error("result without operation");

    // no new transaction while one is in progress
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == ST_LOOKUP))
        else $error("transaction accepted outside idle");
`endif

endmodule

@@ test/keyed_multi_fifo_test.sv @@
// ----------------------------------------------------------------------------
// keyed_multi_fifo_test
// Self-checking bench for the keyed multi-queue FIFO. A directed table covers
// reset state, key extremes, duplicate keys, slot reuse and the not-found and empty codes.
// Random key-pool traffic follows: register/unregister churn, push and pop
// bursts that run queues full and empty, and noise. A behavioral model of the
// slot table and record store predicts every result. Both channels idle at
// random.
// ----------------------------------------------------------------------------
module keyed_multi_fifo_test;

    localparam int NQ     = kmf_pkg::NumQueuesDef;
    localparam int DEPTH  = kmf_pkg::QueueDepthDef;
    localparam int REC_W  = kmf_pkg::RecordWidthDef;
    localparam logic [kmf_pkg::RecPortW-1:0] REC_MASK =
        {kmf_pkg::RecPortW{1'b1}} >> (kmf_pkg::RecPortW - REC_W);
    localparam int NUM_RANDOM = 900;
    localparam int POOL_SIZE  = 6;

    // one result transaction
    typedef struct packed {
        kmf_pkg::status_t               status;
        logic [kmf_pkg::RecPortW-1:0]   rec;
    } queue_result_t;

    // one row of the directed stimulus; typed_exp marks rows with a hand-typed result
    typedef struct {
        kmf_pkg::op_t                   op;
        logic [kmf_pkg::KeyW-1:0]       qkey;
        logic [kmf_pkg::RecPortW-1:0]   rec;
        bit                             typed_exp;
        kmf_pkg::status_t               exp_status;
        logic [kmf_pkg::RecPortW-1:0]   exp_rec;
    } stim_row_t;

    logic                           aclk;
    logic                           aresetn;
    logic                           s_valid;
    logic                           s_ready;
    logic [kmf_pkg::OpW-1:0]        s_operation;
    logic [kmf_pkg::KeyW-1:0]       s_queue_key;
    logic [kmf_pkg::RecPortW-1:0]   s_push_record;
    logic                           m_valid;
    logic                           m_ready;
    logic [kmf_pkg::StatusW-1:0]    m_status;
    logic [kmf_pkg::RecPortW-1:0]   m_popped_record;

    keyed_multi_fifo dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_operation     (s_operation),
        .s_queue_key     (s_queue_key),
        .s_push_record   (s_push_record),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_popped_record (m_popped_record)
    );

    // ------------------------------------------------------------------
    // Model of the slot table and the shared record store
    // ------------------------------------------------------------------
    bit                             slot_busy [NQ];
    logic [kmf_pkg::KeyW-1:0]       slot_tag  [NQ];
    int                             q_head    [NQ];
    int                             q_fill    [NQ];
    logic [kmf_pkg::RecPortW-1:0]   rec_mem   [NQ*DEPTH];

    queue_result_t         pending_results [$];   // results still owed by the DUT
    queue_result_t         oldest;
    queue_result_t         predicted;
    int                    err_count = 0;

    // typed result for the transaction currently on the input channel
    bit                    cur_typed;
    queue_result_t         cur_typed_res;

    stim_row_t                  directed_rows [$];
    logic [kmf_pkg::KeyW-1:0]   key_pool [POOL_SIZE];
    int                         burst_left = 0;

    // Applies one operation to the model state and returns the result.
    // All lookups take the lowest-index match; free slots never match.
    function automatic queue_result_t predict_queue_op(
        kmf_pkg::op_t op,
        logic [kmf_pkg::KeyW-1:0] qkey,
        logic [kmf_pkg::RecPortW-1:0] rec
    );
        queue_result_t r;
        int s;
        int hit;
        int pos;
        r.status = kmf_pkg::STAT_NOT_FOUND;
        r.rec    = '0;
        hit      = NQ;
        if (op == kmf_pkg::OP_REGISTER) begin
            for (s = NQ - 1; s >= 0; s--)
                if (!slot_busy[s]) hit = s;
            if (hit < NQ) begin
                // reuse keeps old head, count and records
                slot_busy[hit] = 1'b1;
                slot_tag[hit]  = qkey;
                r.status       = kmf_pkg::STAT_OK;
            end
        end else begin
            for (s = NQ - 1; s >= 0; s--)
                if (slot_busy[s] && slot_tag[s] == qkey) hit = s;
            if (hit < NQ) begin
                case (op)
                    kmf_pkg::OP_UNREGISTER: begin
                        slot_busy[hit] = 1'b0;
                        r.status       = kmf_pkg::STAT_OK;
                    end
                    kmf_pkg::OP_PUSH: begin
                        if (q_fill[hit] >= DEPTH) begin
                            r.status = kmf_pkg::STAT_FULL;
                        end else begin
                            pos = (q_head[hit] + q_fill[hit]) % DEPTH;
                            rec_mem[hit*DEPTH + pos] = rec & REC_MASK;
                            q_fill[hit]++;
                            r.status = kmf_pkg::STAT_OK;
                        end
                    end
                    default: begin
                        if (q_fill[hit] == 0) begin
                            r.status = kmf_pkg::STAT_EMPTY;
                        end else begin
                            r.rec       = rec_mem[hit*DEPTH + q_head[hit]] & REC_MASK;
                            q_head[hit] = (q_head[hit] + 1) % DEPTH;
                            q_fill[hit]--;
                            r.status    = kmf_pkg::STAT_OK;
                        end
                    end
                endcase
            end
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Clock and run limit
    // ------------------------------------------------------------------
    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // worst case is ~950 transactions, each with its gap, stall and controller steps, far below this
    initial begin
        #2000000;
        $display("keyed_multi_fifo_test: FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // Monitor: predict on every accepted input transaction, check every
    // accepted result against the oldest pending one. Sampled at the
    // rising edge, before the DUT's own updates land.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                // the model always runs so its state tracks the DUT
                predicted = predict_queue_op(kmf_pkg::op_t'(s_operation), s_queue_key,
                                             s_push_record);
                if (cur_typed)
                    pending_results.push_back(cur_typed_res);
                else
                    pending_results.push_back(predicted);
            end
            if (m_valid && m_ready) begin
                if (pending_results.size() == 0) begin
                    err_count++;
                    $display("%0t: unexpected result: expected none, actual status %0d record %h",
                             $time, m_status, m_popped_record);
                end else begin
                    oldest = pending_results.pop_front();
                    if (m_status !== oldest.status) begin
                        err_count++;
                        $display("%0t: status mismatch: expected %0d, actual %0d",
                                 $time, oldest.status, m_status);
                    end
                    if (m_popped_record !== oldest.rec) begin
                        err_count++;
                        $display("%0t: popped record mismatch: expected %h, actual %h",
                                 $time, oldest.rec, m_popped_record);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: ready follows a pattern that changes at random intervals:
    // always ready, coin flip, mostly stalled, or periodic.
    // ------------------------------------------------------------------
    initial begin
        int mode;
        int left;
        int phase;
        int period;
        mode    = 0;
        left    = 0;
        phase   = 0;
        period  = 2;
        m_ready = 1'b0;
        forever begin
            if (left == 0) begin
                mode   = $urandom_range(0, 3);
                left   = $urandom_range(10, 80);
                period = $urandom_range(2, 6);
            end
            @(negedge aclk);
            left--;
            phase++;
            case (mode)
                0: m_ready <= 1'b1;
                1: m_ready <= $urandom_range(0, 1);
                2: m_ready <= ($urandom_range(0, 4) == 0);
                default: m_ready <= (phase % period != 0);
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Sender helpers
    // ------------------------------------------------------------------

    // Drives one input transaction and waits for its handshake. Bursts of
    // random length are separated by random gaps with valid low.
    task automatic send_txn(kmf_pkg::op_t op, logic [kmf_pkg::KeyW-1:0] qkey,
                            logic [kmf_pkg::RecPortW-1:0] rec, bit typed_exp,
                            kmf_pkg::status_t exp_status,
                            logic [kmf_pkg::RecPortW-1:0] exp_rec);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 20) : $urandom_range(1, 4);
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        burst_left--;
        @(negedge aclk);
        s_valid              <= 1'b1;
        s_operation          <= op;
        s_queue_key          <= qkey;
        s_push_record        <= rec;
        cur_typed            = typed_exp;
        cur_typed_res.status = exp_status;
        cur_typed_res.rec    = exp_rec;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Random-content transaction checked against the model only.
    task automatic send_op(kmf_pkg::op_t op, logic [kmf_pkg::KeyW-1:0] qkey);
        send_txn(op, qkey, {$urandom, $urandom}, 1'b0, kmf_pkg::STAT_OK, '0);
    endtask

    // Holds the input side idle until every pending result has come back.
    task automatic wait_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge aclk);
        burst_left = 0;
    endtask

    task automatic table_row(kmf_pkg::op_t op, logic [kmf_pkg::KeyW-1:0] qkey,
                             logic [kmf_pkg::RecPortW-1:0] rec, bit typed_exp,
                             kmf_pkg::status_t exp_status,
                             logic [kmf_pkg::RecPortW-1:0] exp_rec);
        stim_row_t r;
        r.op         = op;
        r.qkey       = qkey;
        r.rec        = rec;
        r.typed_exp  = typed_exp;
        r.exp_status = exp_status;
        r.exp_rec    = exp_rec;
        directed_rows.push_back(r);
    endtask

    // ------------------------------------------------------------------
    // Main stimulus
    // ------------------------------------------------------------------
    initial begin
        int i;
        int n;
        int sent;
        int kind;
        logic [kmf_pkg::KeyW-1:0] k;
        logic [kmf_pkg::RecPortW-1:0] ones;
        logic [kmf_pkg::RecPortW-1:0] alt;

        ones = {kmf_pkg::RecPortW{1'b1}};
        alt  = {(kmf_pkg::RecPortW/2){2'b01}};

        for (i = 0; i < NQ; i++) begin
            slot_busy[i] = 1'b0;
            slot_tag[i]  = '0;
            q_head[i]    = 0;
            q_fill[i]    = 0;
        end

        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_operation   = kmf_pkg::OP_REGISTER;
        s_queue_key   = '0;
        s_push_record = '0;
        cur_typed     = 1'b0;
        cur_typed_res = '0;

        // small key pool so lookups hit; extremes always in it
        key_pool[0] = '0;
        key_pool[1] = '1;
        key_pool[2] = 32'hA5A5_A5A5;
        for (i = 3; i < POOL_SIZE; i++) key_pool[i] = $urandom;

        // --- directed table -------------------------------------------
        // empty slot table after reset: every lookup misses
        table_row(kmf_pkg::OP_POP,        32'h0, '0,   1'b1, kmf_pkg::STAT_NOT_FOUND, '0);
        table_row(kmf_pkg::OP_UNREGISTER, '1,    '0,   1'b1, kmf_pkg::STAT_NOT_FOUND, '0);
        table_row(kmf_pkg::OP_PUSH,       32'h0, ones, 1'b1, kmf_pkg::STAT_NOT_FOUND, '0);
        // bind key zero, empty pop, then one record round trip
        table_row(kmf_pkg::OP_REGISTER,   32'h0, '0,   1'b1, kmf_pkg::STAT_OK,        '0);
        table_row(kmf_pkg::OP_POP,        32'h0, ones, 1'b1, kmf_pkg::STAT_EMPTY,     '0);
        table_row(kmf_pkg::OP_PUSH,       32'h0, ones, 1'b1, kmf_pkg::STAT_OK,        '0);
        table_row(kmf_pkg::OP_POP,        32'h0, '0,   1'b1, kmf_pkg::STAT_OK,        ones);
        // all-ones key, two records, then a duplicate binding
        table_row(kmf_pkg::OP_REGISTER,   '1,    '0,   1'b1, kmf_pkg::STAT_OK,        '0);
        table_row(kmf_pkg::OP_PUSH,       '1,    '0,   1'b1, kmf_pkg::STAT_OK,        '0);
        table_row(kmf_pkg::OP_PUSH,       '1,    alt,  1'b0, kmf_pkg::STAT_OK,        '0);
        table_row(kmf_pkg::OP_REGISTER,   '1,    '0,   1'b0, kmf_pkg::STAT_OK,        '0);
        table_row(kmf_pkg::OP_POP,        '1,    '0,   1'b1, kmf_pkg::STAT_OK,        '0);
        // unregister hits the lowest binding; the duplicate takes over, empty
        table_row(kmf_pkg::OP_UNREGISTER, '1,    '0,   1'b0, kmf_pkg::STAT_OK,        '0);
        table_row(kmf_pkg::OP_POP,        '1,    '0,   1'b0, kmf_pkg::STAT_OK,        '0);
        // slot reuse keeps the leftover record from the freed binding
        table_row(kmf_pkg::OP_REGISTER, key_pool[2], '0, 1'b0, kmf_pkg::STAT_OK, '0);
        table_row(kmf_pkg::OP_POP,      key_pool[2], '0, 1'b0, kmf_pkg::STAT_OK, '0);
        // a freed slot still holds key zero but must not match
        table_row(kmf_pkg::OP_UNREGISTER, 32'h0, '0,   1'b0, kmf_pkg::STAT_OK,        '0);
        table_row(kmf_pkg::OP_PUSH,       32'h0, ones, 1'b0, kmf_pkg::STAT_OK,        '0);
        // fill every slot, then one more register finds no free slot
        for (i = 0; i < POOL_SIZE; i++)
            table_row(kmf_pkg::OP_REGISTER, key_pool[i], '0, 1'b0, kmf_pkg::STAT_OK, '0);
        table_row(kmf_pkg::OP_REGISTER, key_pool[3], '0, 1'b1, kmf_pkg::STAT_NOT_FOUND, '0);

        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        foreach (directed_rows[j])
            send_txn(directed_rows[j].op, directed_rows[j].qkey, directed_rows[j].rec,
                     directed_rows[j].typed_exp, directed_rows[j].exp_status,
                     directed_rows[j].exp_rec);

        // sender holds off until the pipeline is empty
        wait_drained();

        // --- random traffic --------------------------------------------
        // Mostly well-formed sequences on pool keys; push/pop bursts of up
        // to 20 run queues past full and empty. Noise uses arbitrary keys.
        sent = 0;
        while (sent < NUM_RANDOM) begin
            k    = key_pool[$urandom_range(0, POOL_SIZE - 1)];
            kind = $urandom_range(0, 9);
            case (kind)
                0, 1: begin
                    send_op(kmf_pkg::OP_REGISTER, k);
                    sent++;
                end
                2, 3, 4: begin
                    n = $urandom_range(1, 20);
                    for (i = 0; i < n; i++) send_op(kmf_pkg::OP_PUSH, k);
                    sent += n;
                end
                5, 6: begin
                    n = $urandom_range(1, 20);
                    for (i = 0; i < n; i++) send_op(kmf_pkg::OP_POP, k);
                    sent += n;
                end
                7: begin
                    send_op(kmf_pkg::OP_UNREGISTER, k);
                    sent++;
                end
                8: begin
                    n = $urandom_range(1, 8);
                    for (i = 0; i < n; i++)
                        send_op(kmf_pkg::op_t'($urandom_range(0, 3)),
                                key_pool[$urandom_range(0, POOL_SIZE - 1)]);
                    sent += n;
                end
                default: begin
                    // noise: arbitrary key half the time, which mostly misses
                    send_op(kmf_pkg::op_t'($urandom_range(0, 3)),
                            ($urandom_range(0, 1) == 0) ? $urandom : k);
                    sent++;
                end
            endcase
            if ($urandom_range(0, 24) == 0) wait_drained();
        end

        // --- end of run ----------------------------------------------------
        wait_drained();
        // extra idle time so any stray result shows up
        repeat (20) @(posedge aclk);
        if (err_count == 0)
            $display("keyed_multi_fifo_test: PASS");
        else
            $display("keyed_multi_fifo_test: FAIL");
        $finish;
    end

endmodule
